/* rtl/mdfs_pkg.sv */
package mdfs_pkg;

   // default grid side
   localparam int GRID_SIDE_DEF = 16;

   // item modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_SOLVE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // cell marks and search directions
   localparam logic [2:0] MARK_FREE    = 3'd0;
   localparam logic [2:0] MARK_BLOCKED = 3'd1;
   localparam logic [2:0] MARK_DEAD    = 3'd2;
   localparam logic [2:0] DIR_EAST     = 3'd3;
   localparam logic [2:0] DIR_SOUTH    = 3'd4;
   localparam logic [2:0] DIR_WEST     = 3'd5;
   localparam logic [2:0] DIR_NORTH    = 3'd6;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] row;
      logic [3:0] col;
      logic       cell_blocked;
      logic [3:0] start_row;
      logic [3:0] start_col;
      logic [3:0] end_row;
      logic [3:0] end_col;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [8:0] path_length;
      logic [2:0] cell_mark;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PROBE,
      ST_CHECK,
      ST_POP,
      ST_FOUND,
      ST_ZERO
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CELL_WR,
      OP_CELL_RD,
      OP_START,
      OP_PROBE,
      OP_ENTER,
      OP_POP,
      OP_DEAD,
      OP_ADVANCE
   } op_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_MARK,
      RSP_FOUND
   } rsp_sel_type;

   typedef struct packed {
      op_type      op;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic enterable;
      logic at_end;
      logic depth_zero;
      logic top_north;
   } status_type;

endpackage

/* rtl/mdfs_ram.sv */
module mdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mdfs_datapath.sv */
module mdfs_datapath #(
   parameter int GRID_SIDE = mdfs_pkg::GRID_SIDE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mdfs_pkg::req_type    req,
   input  mdfs_pkg::cmd_type    cmd,
   output mdfs_pkg::status_type status,
   output mdfs_pkg::rsp_type    rsp
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int IDXW  = $clog2(GRID_SIDE);
   localparam int AW    = $clog2(CELLS);
   localparam int DW    = $clog2(CELLS + 1);
   localparam int SW    = 2 * IDXW + 3;
   localparam logic [IDXW-1:0] LAST = IDXW'(GRID_SIDE - 1);

   // search position, target, stack depth, clear sweep
   logic [IDXW-1:0] cur_r_ff, cur_r_in;
   logic [IDXW-1:0] cur_c_ff, cur_c_in;
   logic            cur_off_ff, cur_off_in;
   logic [3:0]      end_r_ff, end_c_ff;
   logic [DW-1:0]   depth_ff, depth_in;
   logic [AW-1:0]   clr_cnt_ff;
   logic            rd_oor_ff;
   mdfs_pkg::rsp_type rsp_ff, rsp_in;

   // memory ports
   logic          grid_we, grid_re;
   logic [AW-1:0] grid_wa, grid_ra;
   logic [2:0]    grid_wd, grid_rd;
   logic          stk_we, stk_re;
   logic [AW-1:0] stk_wa, stk_ra;
   logic [SW-1:0] stk_wd, stk_rd;

   logic [IDXW-1:0] e_r, e_c;
   logic [2:0]      e_dir, next_dir;
   logic [IDXW-1:0] step_r, step_c;
   logic            step_off;
   logic            req_in_range, start_in_range;
   logic [AW-1:0]   req_addr, cur_addr, e_addr;
   logic [DW-1:0]   depth_m1;

   mdfs_ram #(.WIDTH(3), .DEPTH(CELLS)) u_grid (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_wa),
      .wr_data (grid_wd),
      .rd_en   (grid_re),
      .rd_addr (grid_ra),
      .rd_data (grid_rd)
   );

   mdfs_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // popped stack entry
   assign e_r      = stk_rd[SW-1 -: IDXW];
   assign e_c      = stk_rd[SW-IDXW-1 -: IDXW];
   assign e_dir    = stk_rd[2:0];
   assign next_dir = e_dir + 3'd1;

   // cell addresses
   assign req_in_range   = (32'(req.row) < GRID_SIDE) && (32'(req.col) < GRID_SIDE);
   assign start_in_range = (32'(req.start_row) < GRID_SIDE) &&
                           (32'(req.start_col) < GRID_SIDE);
   assign req_addr = AW'(32'(req.row) * GRID_SIDE + 32'(req.col));
   assign cur_addr = AW'(32'(cur_r_ff) * GRID_SIDE + 32'(cur_c_ff));
   assign e_addr   = AW'(32'(e_r) * GRID_SIDE + 32'(e_c));
   assign depth_m1 = depth_ff - DW'(1);

   // neighbor of the popped cell in its new direction
   always_comb begin
      step_r   = e_r;
      step_c   = e_c;
      step_off = 1'b0;
      case (next_dir)
         mdfs_pkg::DIR_EAST: begin
            step_c   = e_c + IDXW'(1);
            step_off = (e_c == LAST);
         end
         mdfs_pkg::DIR_SOUTH: begin
            step_r   = e_r + IDXW'(1);
            step_off = (e_r == LAST);
         end
         mdfs_pkg::DIR_WEST: begin
            step_c   = e_c - IDXW'(1);
            step_off = (e_c == '0);
         end
         default: begin
            step_r   = e_r - IDXW'(1);
            step_off = (e_r == '0);
         end
      endcase
   end

   // memory port selection
   always_comb begin
      grid_we = 1'b0;
      grid_wa = cur_addr;
      grid_wd = mdfs_pkg::MARK_FREE;
      grid_re = 1'b0;
      grid_ra = cur_off_ff ? '0 : cur_addr;
      stk_we  = 1'b0;
      stk_wa  = depth_ff[AW-1:0];
      stk_wd  = {cur_r_ff, cur_c_ff, mdfs_pkg::DIR_EAST};
      stk_re  = 1'b0;
      stk_ra  = depth_m1[AW-1:0];
      case (cmd.op)
         mdfs_pkg::OP_CLEAR: begin
            grid_we = 1'b1;
            grid_wa = clr_cnt_ff;
         end
         mdfs_pkg::OP_CELL_WR: begin
            grid_we = req_in_range;
            grid_wa = req_addr;
            grid_wd = req.cell_blocked ? mdfs_pkg::MARK_BLOCKED : mdfs_pkg::MARK_FREE;
         end
         mdfs_pkg::OP_CELL_RD: begin
            grid_re = req_in_range;
            grid_ra = req_addr;
         end
         mdfs_pkg::OP_PROBE: begin
            grid_re = 1'b1;
         end
         mdfs_pkg::OP_ENTER: begin
            grid_we = 1'b1;
            grid_wd = mdfs_pkg::DIR_EAST;
            stk_we  = 1'b1;
         end
         mdfs_pkg::OP_POP: begin
            stk_re = 1'b1;
         end
         mdfs_pkg::OP_DEAD: begin
            grid_we = 1'b1;
            grid_wa = e_addr;
            grid_wd = mdfs_pkg::MARK_DEAD;
            stk_re  = 1'b1;
         end
         mdfs_pkg::OP_ADVANCE: begin
            grid_we = 1'b1;
            grid_wa = e_addr;
            grid_wd = next_dir;
            stk_we  = 1'b1;
            stk_wd  = {e_r, e_c, next_dir};
         end
         default: begin
         end
      endcase
   end

   // next position and depth
   always_comb begin
      cur_r_in   = cur_r_ff;
      cur_c_in   = cur_c_ff;
      cur_off_in = cur_off_ff;
      depth_in   = depth_ff;
      case (cmd.op)
         mdfs_pkg::OP_START: begin
            cur_r_in   = IDXW'(req.start_row);
            cur_c_in   = IDXW'(req.start_col);
            cur_off_in = !start_in_range;
            depth_in   = '0;
         end
         mdfs_pkg::OP_ENTER: begin
            cur_c_in   = cur_c_ff + IDXW'(1);
            cur_off_in = (cur_c_ff == LAST);
            depth_in   = depth_ff + DW'(1);
         end
         mdfs_pkg::OP_POP, mdfs_pkg::OP_DEAD: begin
            depth_in = depth_m1;
         end
         mdfs_pkg::OP_ADVANCE: begin
            cur_r_in   = step_r;
            cur_c_in   = step_c;
            cur_off_in = step_off;
            depth_in   = depth_ff + DW'(1);
         end
         default: begin
         end
      endcase
   end

   // result value
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in = '0;
         case (cmd.rsp_sel)
            mdfs_pkg::RSP_MARK: begin
               rsp_in.cell_mark = rd_oor_ff ? mdfs_pkg::MARK_BLOCKED : grid_rd;
            end
            mdfs_pkg::RSP_FOUND: begin
               rsp_in.found       = 1'b1;
               rsp_in.path_length = 9'(depth_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         clr_cnt_ff <= '0;
      end else begin
         depth_ff <= depth_in;
         if (cmd.op == mdfs_pkg::OP_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_r_ff   <= cur_r_in;
      cur_c_ff   <= cur_c_in;
      cur_off_ff <= cur_off_in;
      rsp_ff     <= rsp_in;
      if (cmd.op == mdfs_pkg::OP_START) begin
         end_r_ff <= req.end_row;
         end_c_ff <= req.end_col;
      end
      if (cmd.op == mdfs_pkg::OP_CELL_RD) begin
         rd_oor_ff <= !req_in_range;
      end
   end

   // status toward the controller
   assign status.clr_last   = (clr_cnt_ff == AW'(CELLS - 1));
   assign status.enterable  = !cur_off_ff && (grid_rd == mdfs_pkg::MARK_FREE);
   assign status.at_end     = (32'(cur_r_ff) == 32'(end_r_ff)) &&
                              (32'(cur_c_ff) == 32'(end_c_ff));
   assign status.depth_zero = (depth_ff == '0);
   assign status.top_north  = (e_dir == mdfs_pkg::DIR_NORTH);

   assign rsp = rsp_ff;

endmodule

/* rtl/mdfs_ctrl.sv */
module mdfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mdfs_pkg::status_type status,
   output mdfs_pkg::cmd_type    cmd
);

   mdfs_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   // output register can take a result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdfs_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.op      = mdfs_pkg::OP_NONE;
      cmd.load_rsp = 1'b0;
      cmd.rsp_sel = mdfs_pkg::RSP_ZERO;
      case (state_ff)
         mdfs_pkg::ST_CLEAR: begin
            cmd.op = mdfs_pkg::OP_CLEAR;
            if (status.clr_last) begin
               state_in = mdfs_pkg::ST_IDLE;
            end
         end
         mdfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  mdfs_pkg::MODE_SOLVE: begin
                     cmd.op   = mdfs_pkg::OP_START;
                     state_in = mdfs_pkg::ST_PROBE;
                  end
                  mdfs_pkg::MODE_READ: begin
                     cmd.op   = mdfs_pkg::OP_CELL_RD;
                     state_in = mdfs_pkg::ST_READ;
                  end
                  default: begin
                     if (req_mode == mdfs_pkg::MODE_WRITE) begin
                        cmd.op = mdfs_pkg::OP_CELL_WR;
                     end
                     if (slot_free) begin
                        cmd.load_rsp = 1'b1;
                     end else begin
                        state_in = mdfs_pkg::ST_ZERO;
                     end
                  end
               endcase
            end
         end
         mdfs_pkg::ST_READ: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = mdfs_pkg::RSP_MARK;
               state_in     = mdfs_pkg::ST_IDLE;
            end
         end
         mdfs_pkg::ST_PROBE: begin
            cmd.op   = mdfs_pkg::OP_PROBE;
            state_in = mdfs_pkg::ST_CHECK;
         end
         mdfs_pkg::ST_CHECK: begin
            if (status.enterable) begin
               cmd.op   = mdfs_pkg::OP_ENTER;
               state_in = status.at_end ? mdfs_pkg::ST_FOUND : mdfs_pkg::ST_PROBE;
            end else if (!status.depth_zero) begin
               cmd.op   = mdfs_pkg::OP_POP;
               state_in = mdfs_pkg::ST_POP;
            end else begin
               state_in = mdfs_pkg::ST_ZERO;
            end
         end
         mdfs_pkg::ST_POP: begin
            if (!status.top_north) begin
               cmd.op   = mdfs_pkg::OP_ADVANCE;
               state_in = mdfs_pkg::ST_PROBE;
            end else if (!status.depth_zero) begin
               // exhausted entry: dead end, pop the one below
               cmd.op = mdfs_pkg::OP_DEAD;
            end else begin
               state_in = mdfs_pkg::ST_ZERO;
            end
         end
         mdfs_pkg::ST_FOUND: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = mdfs_pkg::RSP_FOUND;
               state_in     = mdfs_pkg::ST_IDLE;
            end
         end
         mdfs_pkg::ST_ZERO: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = mdfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdfs_pkg::ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/maze_dfs_path_search_top.sv */
// Channel   Ports                                   Moves
// req       req_valid, req_ready, req_payload       write, solve or read item
// rsp       rsp_valid, rsp_ready, rsp_payload       one result per item
//
// Cell write and unused mode: 1 cycle per item while the output register is free.
// Cell read: a registered grid memory read, then the result load.
// Solve: the item is taken, then each cell probed takes a grid read and a test, each
// stack pop takes a stack read, and the result load comes last; the search loop runs
// over the grid and stack memories.
// After reset a clearing pass writes every grid cell free, with req_ready low. A
// stalled result holds; the next item may be taken.
module maze_dfs_path_search_top #(
   parameter int GRID_SIDE = mdfs_pkg::GRID_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdfs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdfs_pkg::rsp_type rsp_payload
);

   mdfs_pkg::cmd_type    cmd;
   mdfs_pkg::status_type status;

   mdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdfs_datapath #(.GRID_SIDE(GRID_SIDE)) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_payload),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_payload)
   );

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a waiting result");

   // pops only from a nonempty stack
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mdfs_pkg::OP_POP || cmd.op == mdfs_pkg::OP_DEAD) |-> !status.depth_zero)
      else $error("stack pop while empty");

   // only a found search carries a length, and it carries no mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.found || rsp_payload.path_length == '0) &&
                     (!rsp_payload.found || rsp_payload.cell_mark == '0)))
      else $error("inconsistent result fields");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int SIDE = mdfs_pkg::GRID_SIDE_DEF;
   localparam int CELLS = SIDE * SIDE;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASE_ITEMS = 440;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mdfs_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mdfs_pkg::rsp_type rsp_payload;

   // predicted maze state
   logic [2:0] maze_marks [CELLS];
   int         trail_row [CELLS];
   int         trail_col [CELLS];
   logic [2:0] trail_dir [CELLS];
   int         trail_depth = 0;

   mdfs_pkg::rsp_type awaited_results [$];
   int      fault_count = 0;
   int      cycle_count = 0;
   int      items_sent = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   maze_dfs_path_search_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      mdfs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: found=%0d len=%0d mark=%0d",
                        rsp_payload.found, rsp_payload.path_length, rsp_payload.cell_mark);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_payload.found !== want.found ||
                rsp_payload.path_length !== want.path_length ||
                rsp_payload.cell_mark !== want.cell_mark) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected found=%0d len=%0d mark=%0d, got %0d %0d %0d",
                           want.found, want.path_length, want.cell_mark,
                           rsp_payload.found, rsp_payload.path_length,
                           rsp_payload.cell_mark);
            end
         end
      end
   end

   function automatic void push_trail(int r, int c, logic [2:0] dir);
      if (trail_depth < CELLS) begin
         trail_row[trail_depth] = r;
         trail_col[trail_depth] = c;
         trail_dir[trail_depth] = dir;
         trail_depth++;
      end
   endfunction

   // depth-first search; marks stay in the grid afterwards
   function automatic bit solve_maze(int sr, int sc, int er, int ec);
      int         cr;
      int         cc;
      int         tr;
      int         tc;
      logic [2:0] td;
      cr = sr;
      cc = sc;
      trail_depth = 0;
      do begin
         if (cr >= 0 && cc >= 0 && cr < SIDE && cc < SIDE &&
             maze_marks[cr * SIDE + cc] == mdfs_pkg::MARK_FREE) begin
            maze_marks[cr * SIDE + cc] = mdfs_pkg::DIR_EAST;
            push_trail(cr, cc, mdfs_pkg::DIR_EAST);
            if (cr == er && cc == ec) return 1'b1;
            cc = cc + 1;
         end else if (trail_depth > 0) begin
            // back up, turning exhausted cells into dead ends
            trail_depth--;
            tr = trail_row[trail_depth];
            tc = trail_col[trail_depth];
            td = trail_dir[trail_depth];
            while (td == mdfs_pkg::DIR_NORTH && trail_depth > 0) begin
               maze_marks[tr * SIDE + tc] = mdfs_pkg::MARK_DEAD;
               trail_depth--;
               tr = trail_row[trail_depth];
               tc = trail_col[trail_depth];
               td = trail_dir[trail_depth];
            end
            // an exhausted last cell keeps its north mark
            if (td != mdfs_pkg::DIR_NORTH) begin
               td = td + 3'd1;
               maze_marks[tr * SIDE + tc] = td;
               push_trail(tr, tc, td);
               cr = tr;
               cc = tc;
               case (td)
                  mdfs_pkg::DIR_SOUTH: cr = tr + 1;
                  mdfs_pkg::DIR_WEST:  cc = tc - 1;
                  mdfs_pkg::DIR_NORTH: cr = tr - 1;
                  default:             cc = tc + 1;
               endcase
            end
         end
      end while (trail_depth > 0);
      return 1'b0;
   endfunction

   function automatic mdfs_pkg::rsp_type apply_maze_item(mdfs_pkg::req_type item);
      mdfs_pkg::rsp_type res;
      bit      on_grid;
      res = '0;
      on_grid = (int'(item.row) < SIDE) && (int'(item.col) < SIDE);
      case (item.mode)
         mdfs_pkg::MODE_WRITE: begin
            if (on_grid)
               maze_marks[int'(item.row) * SIDE + int'(item.col)] =
                  item.cell_blocked ? mdfs_pkg::MARK_BLOCKED : mdfs_pkg::MARK_FREE;
         end
         mdfs_pkg::MODE_SOLVE: begin
            if (solve_maze(int'(item.start_row), int'(item.start_col),
                           int'(item.end_row), int'(item.end_col))) begin
               res.found = 1'b1;
               res.path_length = 9'(trail_depth);
            end
         end
         mdfs_pkg::MODE_READ: begin
            res.cell_mark = on_grid ?
               maze_marks[int'(item.row) * SIDE + int'(item.col)] : mdfs_pkg::MARK_BLOCKED;
         end
         default: ;
      endcase
      return res;
   endfunction

   // drive one item and record its prediction once accepted
   task automatic send_item(input mdfs_pkg::req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      awaited_results.push_back(apply_maze_item(item));
      items_sent++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   function automatic mdfs_pkg::req_type noise_item();
      logic [31:0]                          rand_word;
      logic [$bits(mdfs_pkg::req_type)-1:0] raw;
      rand_word = $urandom;
      raw = rand_word[$bits(mdfs_pkg::req_type)-1:0];
      return raw;
   endfunction

   task automatic send_cell_write(input int r, input int c, input bit blocked);
      mdfs_pkg::req_type item;
      item = noise_item();
      item.mode = mdfs_pkg::MODE_WRITE;
      item.row = 4'(r);
      item.col = 4'(c);
      item.cell_blocked = blocked;
      send_item(item);
   endtask

   task automatic send_cell_read(input int r, input int c);
      mdfs_pkg::req_type item;
      item = noise_item();
      item.mode = mdfs_pkg::MODE_READ;
      item.row = 4'(r);
      item.col = 4'(c);
      send_item(item);
   endtask

   task automatic send_solve(input int sr, input int sc, input int er, input int ec);
      mdfs_pkg::req_type item;
      item = noise_item();
      item.mode = mdfs_pkg::MODE_SOLVE;
      item.start_row = 4'(sr);
      item.start_col = 4'(sc);
      item.end_row = 4'(er);
      item.end_col = 4'(ec);
      send_item(item);
   endtask

   // corner cells, both cell values, unused mode
   task automatic test_cell_access();
      mdfs_pkg::req_type item;
      send_cell_write(0, 0, 1'b1);
      send_cell_write(SIDE - 1, SIDE - 1, 1'b1);
      send_cell_write(0, SIDE - 1, 1'b0);
      send_cell_write(SIDE - 1, 0, 1'b1);
      send_cell_read(0, 0);
      send_cell_read(SIDE - 1, SIDE - 1);
      send_cell_read(0, SIDE - 1);
      item = '1;
      item.mode = MODE_UNUSED;
      send_item(item);
      send_cell_write(SIDE - 1, SIDE - 1, 1'b0);
      send_cell_read(SIDE - 1, SIDE - 1);
   endtask

   task automatic test_search_cases();
      // start on a wall
      send_solve(SIDE - 1, 0, 3, 3);
      // start is the target
      send_solve(7, 7, 7, 7);
      // start already marked by the previous search
      send_solve(7, 7, 7, 8);
      // boxed-in corner: last cell stays marked north
      send_cell_write(SIDE - 1, SIDE - 2, 1'b1);
      send_cell_write(SIDE - 2, SIDE - 1, 1'b1);
      send_solve(SIDE - 1, SIDE - 1, 0, 0);
      send_cell_read(SIDE - 1, SIDE - 1);
      // straight run east
      send_solve(5, 0, 5, 6);
      hold_until_drained();
      send_cell_read(5, 3);
      // unreachable target floods the grid with dead ends
      send_solve(9, 0, 0, 0);
      send_cell_read(9, 1);
      send_cell_read(10, 0);
   endtask

   // carve a random maze in a box, search it, then probe the marks
   task automatic run_maze_round();
      int h;
      int w;
      int top;
      int left;
      int free_pct;
      int sr;
      int sc;
      int er;
      int ec;
      // old search marks become walls
      for (int i = 0; i < CELLS; i++) begin
         if (maze_marks[i] >= mdfs_pkg::MARK_DEAD) send_cell_write(i / SIDE, i % SIDE, 1'b1);
      end
      if ($urandom_range(0, 99) < 12) begin
         h = $urandom_range(7, SIDE);
         w = $urandom_range(7, SIDE);
      end else begin
         h = $urandom_range(2, 6);
         w = $urandom_range(2, 6);
      end
      top = $urandom_range(0, SIDE - h);
      left = $urandom_range(0, SIDE - w);
      free_pct = $urandom_range(55, 85);
      for (int r = top; r < top + h; r++) begin
         for (int c = left; c < left + w; c++) begin
            send_cell_write(r, c, $urandom_range(0, 99) >= free_pct);
         end
      end
      sr = top + $urandom_range(0, h - 1);
      sc = left + $urandom_range(0, w - 1);
      if ($urandom_range(0, 99) < 15) begin
         er = $urandom_range(0, SIDE - 1);
         ec = $urandom_range(0, SIDE - 1);
      end else begin
         er = top + $urandom_range(0, h - 1);
         ec = left + $urandom_range(0, w - 1);
      end
      if ($urandom_range(0, 99) < 75) begin
         send_cell_write(sr, sc, 1'b0);
         send_cell_write(er, ec, 1'b0);
      end
      send_solve(sr, sc, er, ec);
      repeat ($urandom_range(2, 6)) begin
         if ($urandom_range(0, 99) < 80)
            send_cell_read(top + $urandom_range(0, h - 1), left + $urandom_range(0, w - 1));
         else
            send_cell_read($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
      end
      // search again over the marks just left
      if ($urandom_range(0, 99) < 35)
         send_solve(top + $urandom_range(0, h - 1), left + $urandom_range(0, w - 1),
                    top + $urandom_range(0, h - 1), left + $urandom_range(0, w - 1));
      if ($urandom_range(0, 99) < 25) begin
         repeat ($urandom_range(1, 4)) send_item(noise_item());
      end
   endtask

   task automatic test_random_mazes(input int idle_pct, input int stall_pct,
                                    input bit wall_fill);
      int target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + PHASE_ITEMS;
      // walls everywhere so that searches stay inside the carved boxes
      if (wall_fill) begin
         for (int i = 0; i < CELLS; i++) send_cell_write(i / SIDE, i % SIDE, 1'b1);
      end
      while (items_sent < target) run_maze_round();
      hold_until_drained();
   endtask

   initial begin
      foreach (maze_marks[i]) maze_marks[i] = mdfs_pkg::MARK_FREE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_cell_access();
      test_search_cases();
      hold_until_drained();
      test_random_mazes(0, 0, 1'b1);
      test_random_mazes(88, 0, 1'b0);
      test_random_mazes(0, 88, 1'b0);
      test_random_mazes(25, 25, 1'b0);

      hold_until_drained();
      repeat (50) @(posedge clock);
      if (fault_count == 0 && awaited_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mdfs_pkg.sv
rtl/mdfs_ram.sv
rtl/mdfs_datapath.sv
rtl/mdfs_ctrl.sv
rtl/maze_dfs_path_search_top.sv
dv/testbench.sv
